@@ hdl/jse_pkg.sv @@
// Shared types, character codes and helper functions of the JSON string escaper.
// Used by jse_front, jse_back and json_string_escaper; depends on nothing.
`default_nettype none

package jse_pkg;

    // Depth of the command queue between front and back, in items
    localparam int QUEUE_DEPTH = 4;

    // Token slots per command; one input item produces at most five
    localparam int MAX_TOK = 6;

    // Token kinds: what the back end expands a token into
    localparam logic [1:0] TK_RAW   = 2'd0;  // the byte itself
    localparam logic [1:0] TK_ESC   = 2'd1;  // backslash, then the byte
    localparam logic [1:0] TK_HEX   = 2'd2;  // \u00xx of the byte
    localparam logic [1:0] TK_CLOSE = 2'd3;  // closing quote, end of string

    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5c;
    localparam logic [7:0] CH_U      = 8'h75;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_LOW_A  = 8'h61;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] data;
    } tok_t;

    // One item's worth of work for the back end
    typedef struct packed {
        tok_t [MAX_TOK-1:0] toks;
        logic [2:0]         n;
    } cmd_t;

    // Outcome of handling a byte while nothing is held
    typedef struct packed {
        logic       emit;
        tok_t       tok;
        logic       hold;
        logic [2:0] seq_len;
    } fresh_t;

    function automatic logic is_cont(logic [7:0] b);
        return (b & 8'hc0) == 8'h80;
    endfunction

    function automatic logic second_ok(logic [7:0] lead, logic [7:0] second);
        logic ok;
        ok = 1'b1;
        if (lead == 8'he0 && second < 8'ha0) ok = 1'b0;
        if (lead == 8'hed && second > 8'h9f) ok = 1'b0;
        if (lead == 8'hf0 && second < 8'h90) ok = 1'b0;
        if (lead == 8'hf4 && second > 8'h8f) ok = 1'b0;
        return ok;
    endfunction

    function automatic fresh_t fresh_class(logic [7:0] c);
        fresh_t f;
        f = '0;
        unique case (c)
            8'h22: begin f.emit = 1'b1; f.tok = '{TK_ESC, CH_QUOTE};  end
            8'h5c: begin f.emit = 1'b1; f.tok = '{TK_ESC, CH_BSLASH}; end
            8'h08: begin f.emit = 1'b1; f.tok = '{TK_ESC, 8'h62};     end
            8'h0c: begin f.emit = 1'b1; f.tok = '{TK_ESC, 8'h66};     end
            8'h0a: begin f.emit = 1'b1; f.tok = '{TK_ESC, 8'h6e};     end
            8'h0d: begin f.emit = 1'b1; f.tok = '{TK_ESC, 8'h72};     end
            8'h09: begin f.emit = 1'b1; f.tok = '{TK_ESC, 8'h74};     end
            default: begin
                priority if (c < 8'h20) begin
                    f.emit = 1'b1; f.tok = '{TK_HEX, c};
                end else if (c < 8'h80) begin
                    f.emit = 1'b1; f.tok = '{TK_RAW, c};
                end else if (c >= 8'hc2 && c <= 8'hdf) begin
                    f.hold = 1'b1; f.seq_len = 3'd2;
                end else if (c >= 8'he0 && c <= 8'hef) begin
                    f.hold = 1'b1; f.seq_len = 3'd3;
                end else if (c >= 8'hf0 && c <= 8'hf4) begin
                    f.hold = 1'b1; f.seq_len = 3'd4;
                end else begin
                    f.emit = 1'b1; f.tok = '{TK_HEX, c};
                end
            end
        endcase
        return f;
    endfunction

    function automatic logic [2:0] tok_len(logic [1:0] kind);
        logic [2:0] len;
        unique case (kind)
            TK_RAW:   len = 3'd1;
            TK_ESC:   len = 3'd2;
            TK_HEX:   len = 3'd6;
            TK_CLOSE: len = 3'd1;
        endcase
        return len;
    endfunction

    function automatic logic [7:0] hex_char(logic [3:0] nib);
        logic [7:0] ch;
        if (nib < 4'd10) ch = CH_ZERO + {4'd0, nib};
        else             ch = CH_LOW_A + {4'd0, nib} - 8'd10;
        return ch;
    endfunction

endpackage

`default_nettype wire

@@ hdl/jse_front.sv @@
// Front end of the JSON string escaper: accepts bytes, tracks held UTF-8 bytes
// and turns each item into a token command. Depends on jse_pkg.
`default_nettype none

module jse_front (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          s_tvalid,
    output logic               s_tready,
    input  wire logic [7:0]    in_byte,
    input  wire logic          first_byte,
    input  wire logic          last_byte,
    output logic               q_push,
    output jse_pkg::cmd_t      q_cmd,
    input  wire logic          q_full
);
    import jse_pkg::*;

    logic [7:0] held_lead_reg, held_lead_next;
    logic [7:0] held_cont0_reg, held_cont0_next;
    logic [7:0] held_cont1_reg, held_cont1_next;
    logic [1:0] held_count_reg, held_count_next;
    logic [2:0] held_length_reg, held_length_next;

    logic       accept;
    logic [1:0] h_cnt;
    logic [2:0] h_len;
    logic       ok;
    logic       run_fresh;
    fresh_t     fr;
    tok_t [MAX_TOK-1:0] toks;
    logic [2:0] n;

    assign s_tready = !q_full;
    assign accept   = s_tvalid && !q_full;
    assign fr       = fresh_class(in_byte);

    always_comb begin
        toks             = '0;
        n                = '0;
        ok               = 1'b0;
        run_fresh        = 1'b0;
        // a first byte drops whatever a previous string left held
        h_cnt            = first_byte ? 2'd0 : held_count_reg;
        h_len            = first_byte ? 3'd0 : held_length_reg;
        held_lead_next   = held_lead_reg;
        held_cont0_next  = held_cont0_reg;
        held_cont1_next  = held_cont1_reg;
        held_count_next  = h_cnt;
        held_length_next = h_len;

        if (first_byte) begin
            toks[n] = '{TK_RAW, CH_QUOTE};
            n = n + 3'd1;
        end

        if (h_cnt == 2'd0) begin
            run_fresh = 1'b1;
        end else begin
            ok = is_cont(in_byte) && (h_cnt != 2'd1 || second_ok(held_lead_reg, in_byte));
            if (ok) begin
                if ({1'b0, h_cnt} + 3'd1 >= h_len) begin
                    // sequence complete: pass it through raw
                    toks[n] = '{TK_RAW, held_lead_reg};
                    n = n + 3'd1;
                    if (h_cnt >= 2'd2) begin
                        toks[n] = '{TK_RAW, held_cont0_reg};
                        n = n + 3'd1;
                    end
                    if (h_cnt >= 2'd3) begin
                        toks[n] = '{TK_RAW, held_cont1_reg};
                        n = n + 3'd1;
                    end
                    toks[n] = '{TK_RAW, in_byte};
                    n = n + 3'd1;
                    held_count_next  = 2'd0;
                    held_length_next = 3'd0;
                end else begin
                    if (h_cnt == 2'd1) held_cont0_next = in_byte;
                    else               held_cont1_next = in_byte;
                    held_count_next = h_cnt + 2'd1;
                end
            end else begin
                // broken sequence: escape the held bytes, then retry this byte
                toks[n] = '{TK_HEX, held_lead_reg};
                n = n + 3'd1;
                if (h_cnt >= 2'd2) begin
                    toks[n] = '{TK_HEX, held_cont0_reg};
                    n = n + 3'd1;
                end
                if (h_cnt >= 2'd3) begin
                    toks[n] = '{TK_HEX, held_cont1_reg};
                    n = n + 3'd1;
                end
                held_count_next  = 2'd0;
                held_length_next = 3'd0;
                run_fresh        = 1'b1;
            end
        end

        if (run_fresh) begin
            if (fr.emit) begin
                toks[n] = fr.tok;
                n = n + 3'd1;
            end else if (fr.hold) begin
                held_lead_next   = in_byte;
                held_count_next  = 2'd1;
                held_length_next = fr.seq_len;
            end
        end

        if (last_byte) begin
            if (held_count_next >= 2'd1) begin
                toks[n] = '{TK_HEX, held_lead_next};
                n = n + 3'd1;
            end
            if (held_count_next >= 2'd2) begin
                toks[n] = '{TK_HEX, held_cont0_next};
                n = n + 3'd1;
            end
            if (held_count_next >= 2'd3) begin
                toks[n] = '{TK_HEX, held_cont1_next};
                n = n + 3'd1;
            end
            toks[n] = '{TK_CLOSE, CH_QUOTE};
            n = n + 3'd1;
            held_count_next  = 2'd0;
            held_length_next = 3'd0;
        end
    end

    // drop items that produce nothing; only their state update matters
    assign q_push     = accept && (n != 3'd0);
    assign q_cmd.toks = toks;
    assign q_cmd.n    = n;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            held_count_reg  <= 2'd0;
            held_length_reg <= 3'd0;
        end else if (accept) begin
            held_count_reg  <= held_count_next;
            held_length_reg <= held_length_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            held_lead_reg  <= held_lead_next;
            held_cont0_reg <= held_cont0_next;
            held_cont1_reg <= held_cont1_next;
        end
    end

    a_held_within_len: assert property (@(posedge aclk) disable iff (!aresetn)
        held_count_reg != 2'd0 |-> {1'b0, held_count_reg} < held_length_reg)
        else $error("held count reaches sequence length");

    a_push_has_room: assert property (@(posedge aclk) disable iff (!aresetn)
        q_push |-> !q_full)
        else $error("push into full queue");

endmodule

`default_nettype wire

@@ hdl/jse_queue.sv @@
// Small register FIFO that carries token commands from front to back.
// Generic in width and depth; no package dependency.
`default_nettype none

module jse_queue #(
    parameter int Width = 8,
    parameter int Depth = 4
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             push,
    input  wire logic [Width-1:0] push_data,
    output logic                  full,
    input  wire logic             pop,
    output logic [Width-1:0]      pop_data,
    output logic                  empty
);
    localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
    localparam int CntW = $clog2(Depth + 1);

    logic [Width-1:0] mem_reg [Depth];
    logic [PtrW-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PtrW-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CntW-1:0]  count_reg, count_next;

    assign full     = (count_reg == CntW'(Depth));
    assign empty    = (count_reg == '0);
    assign pop_data = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) wr_ptr_next = (wr_ptr_reg == PtrW'(Depth - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)  rd_ptr_next = (rd_ptr_reg == PtrW'(Depth - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !pop)      count_next = count_reg + 1'b1;
        else if (pop && !push) count_next = count_reg - 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) mem_reg[wr_ptr_reg] <= push_data;
    end

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CntW'(Depth))
        else $error("queue count over depth");

endmodule

`default_nettype wire

@@ hdl/jse_back.sv @@
// Back end of the JSON string escaper: expands token commands into output
// bytes, one per cycle while m_tready does not stall it, behind an output register. Depends on jse_pkg.
`default_nettype none

module jse_back (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire jse_pkg::cmd_t q_cmd,
    input  wire logic          q_empty,
    output logic               q_pop,
    output logic               m_tvalid,
    input  wire logic          m_tready,
    output logic [7:0]         m_tdata,
    output logic               m_tlast,
    output logic               m_tuser
);
    import jse_pkg::*;

    cmd_t       cur_reg, cur_next;
    logic       cur_valid_reg, cur_valid_next;
    logic [2:0] tok_idx_reg, tok_idx_next;
    logic [2:0] sub_reg, sub_next;

    logic       m_valid_reg, m_valid_next;
    logic [7:0] m_data_reg;
    logic       m_last_reg, m_user_reg;

    tok_t       tok;
    logic [2:0] len;
    logic       last_sub, last_tok;
    logic       out_adv, emit, finish, load;
    logic [7:0] out_byte;

    assign tok      = cur_reg.toks[tok_idx_reg];
    assign len      = tok_len(tok.kind);
    assign last_sub = (sub_reg == len - 3'd1);
    assign last_tok = (tok_idx_reg == cur_reg.n - 3'd1);
    assign out_adv  = !m_valid_reg || m_tready;
    assign emit     = cur_valid_reg && out_adv;
    assign finish   = emit && last_sub && last_tok;
    assign load     = (!cur_valid_reg || finish) && !q_empty;
    assign q_pop    = load;

    always_comb begin
        unique case (tok.kind)
            TK_RAW:   out_byte = tok.data;
            TK_ESC:   out_byte = (sub_reg == 3'd0) ? CH_BSLASH : tok.data;
            TK_HEX: begin
                unique case (sub_reg)
                    3'd0:    out_byte = CH_BSLASH;
                    3'd1:    out_byte = CH_U;
                    3'd2:    out_byte = CH_ZERO;
                    3'd3:    out_byte = CH_ZERO;
                    3'd4:    out_byte = hex_char(tok.data[7:4]);
                    default: out_byte = hex_char(tok.data[3:0]);
                endcase
            end
            TK_CLOSE: out_byte = CH_QUOTE;
        endcase
    end

    always_comb begin
        cur_next       = cur_reg;
        cur_valid_next = cur_valid_reg;
        tok_idx_next   = tok_idx_reg;
        sub_next       = sub_reg;
        if (load) begin
            cur_next       = q_cmd;
            cur_valid_next = 1'b1;
            tok_idx_next   = 3'd0;
            sub_next       = 3'd0;
        end else if (finish) begin
            cur_valid_next = 1'b0;
        end else if (emit) begin
            if (last_sub) begin
                tok_idx_next = tok_idx_reg + 3'd1;
                sub_next     = 3'd0;
            end else begin
                sub_next = sub_reg + 3'd1;
            end
        end
        m_valid_next = out_adv ? emit : m_valid_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_valid_reg <= 1'b0;
            tok_idx_reg   <= 3'd0;
            sub_reg       <= 3'd0;
            m_valid_reg   <= 1'b0;
        end else begin
            cur_valid_reg <= cur_valid_next;
            tok_idx_reg   <= tok_idx_next;
            sub_reg       <= sub_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cur_reg <= cur_next;
        if (emit) begin
            m_data_reg <= out_byte;
            m_last_reg <= last_sub && last_tok;
            m_user_reg <= (tok.kind == TK_CLOSE);
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tlast  = m_last_reg;
    assign m_tuser  = m_user_reg;

    a_done_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && m_user_reg |-> m_last_reg)
        else $error("closing quote not marked as last of its item");

    a_cmd_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        cur_valid_reg |-> cur_reg.n != 3'd0 && tok_idx_reg < cur_reg.n && sub_reg < len)
        else $error("back end index outside current command");

endmodule

`default_nettype wire

@@ hdl/json_string_escaper.sv @@
// Top level of the JSON string escaper: front end, command queue and back end.
// Depends on jse_pkg, jse_front, jse_queue and jse_back.
`default_nettype none

// The block takes a string one byte per item on the s_ channel and returns its
// JSON-escaped text one byte per item on the m_ channel. s_tuser marks a
// string's first byte (an opening quote goes out before it), s_tlast its final
// byte (held bytes are flushed and a closing quote follows, flagged on m_tuser).
// Quote, backslash, BS, FF, LF, CR and TAB become two-character escapes, other
// control bytes and bytes that are not valid UTF-8 become \u00xx in lower-case
// hex; valid UTF-8 sequences pass through raw once complete. m_tlast marks the
// final output byte caused by each input byte; an input byte that only extends a
// held UTF-8 sequence produces no output at all. Rate: the front end accepts one
// item per cycle as long as the command queue (QUEUE_DEPTH items) has room; the
// back end emits one output byte per cycle while m_tready is high and sets the
// sustained rate; an item has 1 result byte for plain text, 2 for a short escape,
// 6 for \u00xx, up to 25 in the worst case. An input byte passes the command
// queue, the command register and the output register before it is sent out.
module json_string_escaper #(
    parameter int QUEUE_DEPTH = jse_pkg::QUEUE_DEPTH
) (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire logic [7:0] s_tdata,   // [7:0] in_byte
    input  wire logic       s_tuser,   // [0] first_byte
    input  wire logic       s_tlast,   // last_byte
    output logic            m_tvalid,
    input  wire logic       m_tready,
    output logic [7:0]      m_tdata,   // [7:0] out_byte
    output logic            m_tuser,   // [0] string_done
    output logic            m_tlast    // run_last
);
    import jse_pkg::*;

    localparam int CmdW = $bits(cmd_t);

    cmd_t            push_cmd;
    logic [CmdW-1:0] pop_vec;
    cmd_t            pop_cmd;
    logic            q_push, q_pop, q_full, q_empty;

    // classify each byte and track held UTF-8 bytes
    jse_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .in_byte    (s_tdata),
        .first_byte (s_tuser),
        .last_byte  (s_tlast),
        .q_push     (q_push),
        .q_cmd      (push_cmd),
        .q_full     (q_full)
    );

    // decouple the one-item-per-cycle front from the expanding back
    jse_queue #(
        .Width (CmdW),
        .Depth (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data (push_cmd),
        .full      (q_full),
        .pop       (q_pop),
        .pop_data  (pop_vec),
        .empty     (q_empty)
    );

    assign pop_cmd = pop_vec;

    // expand commands into output bytes
    jse_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_cmd    (pop_cmd),
        .q_empty  (q_empty),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    a_pop_not_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |-> !q_empty)
        else $error("pop from empty queue");

endmodule

`default_nettype wire

@@ test/json_escape_check.sv @@
// Checker for the JSON string escaper: watches both stream channels, predicts
// the escaped text of every accepted input byte and compares it byte by byte.
// Depends on jse_pkg for the character codes.
module json_escape_check (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    input  logic              s_tready,
    input  logic [7:0]        s_tdata,
    input  logic              s_tuser,
    input  logic              s_tlast,
    input  logic              m_tvalid,
    input  logic              m_tready,
    input  logic [7:0]        m_tdata,
    input  logic              m_tuser,
    input  logic              m_tlast,
    output int unsigned       fail_count,
    output int unsigned       text_pending
);

    timeunit 1ns;
    timeprecision 1ps;

    import jse_pkg::*;

    localparam logic [7:0] ASC_BS  = 8'h08;
    localparam logic [7:0] ASC_TAB = 8'h09;
    localparam logic [7:0] ASC_LF  = 8'h0a;
    localparam logic [7:0] ASC_FF  = 8'h0c;
    localparam logic [7:0] ASC_CR  = 8'h0d;
    localparam logic [7:0] ESC_B   = 8'h62;
    localparam logic [7:0] ESC_F   = 8'h66;
    localparam logic [7:0] ESC_N   = 8'h6e;
    localparam logic [7:0] ESC_R   = 8'h72;
    localparam logic [7:0] ESC_T   = 8'h74;
    localparam logic [7:0] LEAD_E0 = 8'he0;
    localparam logic [7:0] LEAD_ED = 8'hed;
    localparam logic [7:0] LEAD_F0 = 8'hf0;
    localparam logic [7:0] LEAD_F4 = 8'hf4;

    typedef struct packed {
        logic [7:0] ch;
        logic       run_end;
        logic       str_done;
    } text_byte_t;

    text_byte_t expected_text[$];
    text_byte_t step_text[$];
    text_byte_t want;

    logic [7:0] held_lead;
    logic [7:0] held_cont [2];
    logic [1:0] held_count;
    logic [2:0] held_len;

    function automatic logic [7:0] hex_digit(logic [3:0] nib);
        logic [7:0] d;
        if (nib < 4'd10) d = CH_ZERO + {4'd0, nib};
        else             d = CH_LOW_A + {4'd0, nib} - 8'd10;
        return d;
    endfunction

    // Strict second-byte ranges that rule out overlong forms and surrogates
    function automatic logic second_allowed(logic [7:0] lead, logic [7:0] b);
        logic ok;
        case (lead)
            LEAD_E0: ok = (b >= 8'ha0);
            LEAD_ED: ok = (b <= 8'h9f);
            LEAD_F0: ok = (b >= 8'h90);
            LEAD_F4: ok = (b <= 8'h8f);
            default: ok = 1'b1;
        endcase
        return ok;
    endfunction

    task automatic put_char(input logic [7:0] ch, input logic done);
        text_byte_t t;
        t.ch       = ch;
        t.run_end  = 1'b0;
        t.str_done = done;
        step_text.insert(step_text.size(), t);
    endtask

    task automatic put_hex(input logic [7:0] b);
        put_char(CH_BSLASH, 1'b0);
        put_char(CH_U, 1'b0);
        put_char(CH_ZERO, 1'b0);
        put_char(CH_ZERO, 1'b0);
        put_char(hex_digit(b[7:4]), 1'b0);
        put_char(hex_digit(b[3:0]), 1'b0);
    endtask

    task automatic drop_held();
        held_lead    = '0;
        held_cont[0] = '0;
        held_cont[1] = '0;
        held_count   = '0;
        held_len     = '0;
    endtask

    task automatic flush_held();
        if (held_count >= 2'd1) put_hex(held_lead);
        if (held_count >= 2'd2) put_hex(held_cont[0]);
        if (held_count >= 2'd3) put_hex(held_cont[1]);
        drop_held();
    endtask

    task automatic put_short_esc(input logic [7:0] letter);
        put_char(CH_BSLASH, 1'b0);
        put_char(letter, 1'b0);
    endtask

    // A byte seen while no UTF-8 sequence is open
    task automatic take_fresh(input logic [7:0] c);
        case (c)
            CH_QUOTE, CH_BSLASH: put_short_esc(c);
            ASC_BS:  put_short_esc(ESC_B);
            ASC_FF:  put_short_esc(ESC_F);
            ASC_LF:  put_short_esc(ESC_N);
            ASC_CR:  put_short_esc(ESC_R);
            ASC_TAB: put_short_esc(ESC_T);
            default: begin
                if (c < 8'h20) begin
                    put_hex(c);
                end else if (c < 8'h80) begin
                    put_char(c, 1'b0);
                end else if (c >= 8'hc2 && c <= 8'hdf) begin
                    held_lead = c; held_count = 2'd1; held_len = 3'd2;
                end else if (c >= LEAD_E0 && c <= 8'hef) begin
                    held_lead = c; held_count = 2'd1; held_len = 3'd3;
                end else if (c >= LEAD_F0 && c <= LEAD_F4) begin
                    held_lead = c; held_count = 2'd1; held_len = 3'd4;
                end else begin
                    put_hex(c);
                end
            end
        endcase
    endtask

    // Work out the text one input byte produces and queue it
    task automatic escape_byte(input logic [7:0] c, input logic first, input logic last);
        logic ok;
        step_text.delete();
        if (first) begin
            drop_held();
            put_char(CH_QUOTE, 1'b0);
        end
        if (held_count == 2'd0) begin
            take_fresh(c);
        end else begin
            ok = (c[7:6] == 2'b10) && (held_count != 2'd1 || second_allowed(held_lead, c));
            if (ok) begin
                if ({1'b0, held_count} + 3'd1 >= held_len) begin
                    put_char(held_lead, 1'b0);
                    if (held_count >= 2'd2) put_char(held_cont[0], 1'b0);
                    if (held_count >= 2'd3) put_char(held_cont[1], 1'b0);
                    put_char(c, 1'b0);
                    drop_held();
                end else begin
                    // one held byte fills slot 0, two fill slot 1
                    held_cont[held_count[1]] = c;
                    held_count = held_count + 2'd1;
                end
            end else begin
                flush_held();
                take_fresh(c);
            end
        end
        if (last) begin
            flush_held();
            put_char(CH_QUOTE, 1'b1);
        end
        if (step_text.size() > 0)
            step_text[step_text.size() - 1].run_end = 1'b1;
        foreach (step_text[i]) expected_text.insert(expected_text.size(), step_text[i]);
    endtask

    task automatic report_mismatch(input string what, input int unsigned got,
                                   input int unsigned exp_val);
        $display("[%0t] escaper mismatch: %s got %0h wanted %0h", $time, what, got, exp_val);
        fail_count = fail_count + 1;
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            drop_held();
            expected_text.delete();
            fail_count = 0;
        end else begin
            if (s_tvalid && s_tready)
                escape_byte(s_tdata, s_tuser, s_tlast);
            if (m_tvalid && m_tready) begin
                if (expected_text.size() == 0) begin
                    report_mismatch("unexpected output byte", m_tdata, 0);
                end else begin
                    want = expected_text.pop_front();
                    if (m_tdata != want.ch)
                        report_mismatch("out_byte", m_tdata, want.ch);
                    if (m_tlast != want.run_end)
                        report_mismatch("run_last", m_tlast, want.run_end);
                    if (m_tuser != want.str_done)
                        report_mismatch("string_done", m_tuser, want.str_done);
                end
            end
        end
        text_pending = expected_text.size();
    end

endmodule

@@ test/tb_top.sv @@
// Top of the JSON string escaper testbench: clock, reset, byte stimulus and the
// receiver's back-pressure. Depends on json_string_escaper and json_escape_check.
module tb_top;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_ITEMS  = 70;
    localparam int CALM_ITEMS    = 25;   // random items sent with no idling at all
    localparam int PRESSURE_AT   = 40;   // random item count that triggers the hold-off
    localparam int HOLD_CYCLES   = 300;
    localparam int IDLE_PERCENT  = 28;
    localparam int DRAIN_CYCLES  = 30;

    logic       aclk = 1'b0;
    logic       aresetn;
    logic       s_tvalid;
    logic       s_tready;
    logic [7:0] s_tdata;    // [7:0] in_byte
    logic       s_tuser;    // [0] first_byte
    logic       s_tlast;    // last_byte
    logic       m_tvalid;
    logic       m_tready;
    logic [7:0] m_tdata;    // [7:0] out_byte
    logic       m_tuser;    // [0] string_done
    logic       m_tlast;    // run_last

    int unsigned fail_count;
    int unsigned text_pending;

    logic        idle_on = 1'b1;       // both sides may idle while set
    logic        pressure_req = 1'b0;  // ask the receiver for one long hold-off
    logic [7:0]  str_bytes[$];         // bytes of the string being built
    int unsigned bytes_sent;

    json_string_escaper DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    json_escape_check checker_i (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .s_tuser      (s_tuser),
        .s_tlast      (s_tlast),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .m_tuser      (m_tuser),
        .m_tlast      (m_tlast),
        .fail_count   (fail_count),
        .text_pending (text_pending)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Receiver: drive tready at the falling edge. Normally stall at random; on
    // request hold off for a long stretch so the command queue fills up and the
    // block has to drop s_tready while the sender keeps offering bytes.
    initial begin : receiver
        logic pressure_done;
        pressure_done = 1'b0;
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (pressure_req && !pressure_done) begin
                pressure_done = 1'b1;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
            end else if (idle_on) begin
                m_tready <= ($urandom_range(0, 99) >= IDLE_PERCENT);
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // Hard stop in case the block hangs
    initial begin : watchdog
        #2_000_000;
        $display("Test completed with failures");
        $finish;
    end

    // Offer one byte and hold it until accepted. Entered and left at a falling
    // edge; each idle cycle drops tvalid once, so no step sees two assignments.
    task automatic send_byte(input logic [7:0] b, input logic first, input logic last);
        while (idle_on && $urandom_range(0, 99) < IDLE_PERCENT) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tuser  <= first;
        s_tlast  <= last;
        do @(posedge aclk); while (!s_tready);
        bytes_sent = bytes_sent + 1;
        @(negedge aclk);
    endtask

    // Send str_bytes as one string; mark its ends only where asked
    task automatic send_string(input logic mark_first, input logic mark_last);
        foreach (str_bytes[i])
            send_byte(str_bytes[i], mark_first && i == 0,
                      mark_last && i == str_bytes.size() - 1);
    endtask

    // Append one byte to the string being built
    task automatic add_byte(input logic [7:0] b);
        str_bytes.insert(str_bytes.size(), b);
    endtask

    // Append one well-formed UTF-8 sequence of random length and content
    task automatic push_utf8();
        logic [7:0] lead;
        int unsigned len;
        len = $urandom_range(2, 4);
        case (len)
            2: begin
                add_byte(8'($urandom_range(8'hc2, 8'hdf)));
            end
            3: begin
                lead = 8'($urandom_range(8'he0, 8'hef));
                add_byte(lead);
                if (lead == 8'he0)      add_byte(8'($urandom_range(8'ha0, 8'hbf)));
                else if (lead == 8'hed) add_byte(8'($urandom_range(8'h80, 8'h9f)));
                else                    add_byte(8'($urandom_range(8'h80, 8'hbf)));
            end
            default: begin
                lead = 8'($urandom_range(8'hf0, 8'hf4));
                add_byte(lead);
                if (lead == 8'hf0)      add_byte(8'($urandom_range(8'h90, 8'hbf)));
                else if (lead == 8'hf4) add_byte(8'($urandom_range(8'h80, 8'h8f)));
                else                    add_byte(8'($urandom_range(8'h80, 8'hbf)));
                add_byte(8'($urandom_range(8'h80, 8'hbf)));
            end
        endcase
        // final continuation byte
        add_byte(8'($urandom_range(8'h80, 8'hbf)));
    endtask

    // Build a random string: mostly text, escapes and valid UTF-8, with some
    // cut-off sequences, bad second bytes and raw noise mixed in
    task automatic build_random_string();
        int unsigned units;
        int unsigned pick;
        str_bytes.delete();
        units = $urandom_range(1, 6);
        repeat (units) begin
            pick = $urandom_range(0, 99);
            if (pick < 35)      add_byte(8'($urandom_range(8'h20, 8'h7f)));
            else if (pick < 50) add_byte(8'($urandom_range(8'h00, 8'h1f)));
            else if (pick < 55) add_byte($urandom_range(0, 1) ? 8'h22 : 8'h5c);
            else if (pick < 82) push_utf8();
            else if (pick < 88) begin
                push_utf8();
                void'(str_bytes.pop_back());
            end else if (pick < 94) begin
                add_byte(8'($urandom_range(8'hc2, 8'hf4)));
                add_byte(8'($urandom_range(8'h00, 8'hff)));
            end else begin
                add_byte(8'($urandom_range(8'h00, 8'hff)));
            end
        end
    endtask

    initial begin : stimulus
        int unsigned mode;
        int unsigned random_start;
        aresetn    = 1'b0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        s_tuser    = 1'b0;
        s_tlast    = 1'b0;
        bytes_sent = 0;
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // One-byte string: opening quote, byte, closing quote from one item
        str_bytes = {8'h41};
        send_string(1'b1, 1'b1);

        // Control bytes, every short escape, DEL, a valid pair, a lead broken by
        // a continuation that its second-byte rule rejects, and a stray FF last
        str_bytes = {8'h00, 8'h1f, 8'h22, 8'h5c, 8'h08, 8'h0c, 8'h0a, 8'h0d,
                     8'h09, 8'h7f, 8'hc2, 8'h80, 8'he0, 8'h80, 8'hff};
        send_string(1'b1, 1'b1);

        // Four-byte sequence, surrogate rejected after ED, stray C1 and F5,
        // then a lead left unfinished when the string ends
        str_bytes = {8'hf0, 8'h90, 8'h80, 8'h80, 8'hed, 8'ha0, 8'hc1, 8'hf5, 8'he1};
        send_string(1'b1, 1'b1);

        // A new string starts while a lead is held: the lead is dropped silently
        send_byte(8'he2, 1'b1, 1'b0);
        send_byte(8'h42, 1'b1, 1'b1);

        // Bytes after a closing quote without a first mark
        send_byte(8'h43, 1'b0, 1'b0);
        send_byte(8'hf4, 1'b0, 1'b0);
        send_byte(8'h90, 1'b0, 1'b1);

        // Random strings: start calm, then idle both sides and apply the hold-off
        random_start = bytes_sent;
        idle_on = 1'b0;
        while (bytes_sent - random_start < RANDOM_ITEMS) begin
            if (bytes_sent - random_start >= CALM_ITEMS)  idle_on = 1'b1;
            if (bytes_sent - random_start >= PRESSURE_AT) pressure_req = 1'b1;
            build_random_string();
            mode = $urandom_range(0, 99);
            if (mode < 86)      send_string(1'b1, 1'b1);
            else if (mode < 93) send_string(1'b0, 1'b1);  // no opening mark
            else                send_string(1'b1, 1'b0);  // left open, next first clears it
        end
        s_tvalid <= 1'b0;

        // Drain: wait for every expected byte, then keep watching for strays
        while (text_pending != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
        if (fail_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
